[rtl/core/dpaa_pkg.sv]
`timescale 1ns / 1ps

package dpaa_pkg;

	// stream payload widths
	localparam int IN_DATA_W  = 304;
	localparam int IN_USER_W  = 5;
	localparam int OUT_DATA_W = 264;

	localparam int PORT_W = 16;
	localparam int ADDR_W = 64;
	localparam int ORD_W  = 32;

	// table key: v6 flag, upper word, lower word
	localparam int KEY_W = 2 * ADDR_W + 1;

	// configuration register indexes
	localparam logic REG_SERVICE_PORT  = 1'b0;
	localparam logic REG_HEADER_LENGTH = 1'b1;

	localparam logic [PORT_W-1:0] SERVICE_PORT_RESET  = 16'd53;
	localparam logic [PORT_W-1:0] HEADER_LENGTH_RESET = 16'd12;

	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;

	typedef struct packed {
		logic done;
		logic full;
	} lk_status_t;

	function automatic logic [ORD_W-1:0] swap_bytes32(input logic [ORD_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

[rtl/core/dpaa_ram.sv]
`timescale 1ns / 1ps

module dpaa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/dpaa_lookup.sv]
`timescale 1ns / 1ps

module dpaa_lookup #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dpaa_pkg::KEY_W-1:0]     key,
	output dpaa_pkg::lk_status_t           status,
	output logic [$clog2(TABLE_DEPTH)-1:0] index
);

	import dpaa_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    ptr_q;
	logic [KEY_W-1:0] key_q;
	logic             busy_q;
	logic             rd_valid_s1;
	logic [AW-1:0]    rd_idx_s1;

	logic             rd_en;
	logic [KEY_W-1:0] rd_data;
	logic             match;
	logic             last;
	logic             miss;
	logic             is_full;
	logic             append;

	assign rd_en   = busy_q && (ptr_q < count_q);
	assign match   = rd_valid_s1 && (rd_data == key_q);
	assign last    = rd_valid_s1 && (CW'(rd_idx_s1) == count_q - CW'(1));
	assign miss    = busy_q && ((count_q == '0) || (last && !match));
	assign is_full = (count_q == CW'(TABLE_DEPTH));
	assign append  = miss && !is_full;

	dpaa_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (append),
		.waddr(count_q[AW-1:0]),
		.wdata(key_q),
		.re   (rd_en),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		status.done = match || miss;
		status.full = miss && is_full;
		if (match) begin
			index = rd_idx_s1;
		end else if (append) begin
			index = count_q[AW-1:0];
		end else begin
			index = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			busy_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (start) begin
				busy_q      <= 1'b1;
				ptr_q       <= '0;
				rd_valid_s1 <= 1'b0;
			end else if (status.done) begin
				// drop any read still in flight
				busy_q      <= 1'b0;
				rd_valid_s1 <= 1'b0;
			end else begin
				rd_valid_s1 <= rd_en;
				if (rd_en) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (append) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
		if (rd_en) begin
			rd_idx_s1 <= ptr_q[AW-1:0];
		end
	end

endmodule

[rtl/core/dns_packet_address_anonymizer.sv]
`timescale 1ns / 1ps

// DNS packet address anonymizer.
// s_axis carries one UDP packet summary per item; m_axis returns one result
// item per input item, in order. cfg_we/cfg_index/cfg_data write the service
// port (index 0) and header length (index 1); the user must write them only
// while the block is idle, which the block itself does not enforce. A kept
// IPv4/IPv6 packet has its source (query) or destination (response)
// replaced by the address's first-seen order number from a key table held
// in one registered-read RAM of TABLE_DEPTH entries. A packet that is not
// rewritten goes from input accept straight to the finish state; a
// rewritten one first scans the table in the lookup state, which ends on a
// hit or after the last used entry on a miss. The table scan reads one
// entry per cycle from the RAM port.
// s_axis_tready is high only between items. A finished result waits in the
// output register; the next item is accepted meanwhile, and its result holds
// in the block until m_axis_tready frees the output register.
// Reset clears the entry count and loads the register defaults (53 and 12);
// table contents need no clearing since only counted entries are read.

module dns_packet_address_anonymizer #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// src_port, dst_port, payload_length, source_high, source_low,
	// destination_high, destination_low
	input  logic [dpaa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// ip_version, response_flag
	input  logic [dpaa_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// keep_packet, new_source_high, new_source_low, new_destination_high,
	// new_destination_low, clear_checksum, table_full, zero pad
	output logic [dpaa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [dpaa_pkg::PORT_W-1:0]     cfg_data
);

	import dpaa_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOOKUP = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;

	logic [PORT_W-1:0] service_port_q;
	logic [PORT_W-1:0] header_length_q;

	// input fields
	logic [3:0]        in_ver;
	logic [PORT_W-1:0] in_sport;
	logic [PORT_W-1:0] in_dport;
	logic [PORT_W-1:0] in_plen;
	logic              in_resp;
	logic [ADDR_W-1:0] in_sh, in_sl, in_dh, in_dl;
	logic [ADDR_W-1:0] sel_hi, sel_lo;
	logic              in_keep;
	logic              in_v4;
	logic              in_rewrite;
	logic [KEY_W-1:0]  in_key;
	logic              accept;

	// held item
	logic              keep_q;
	logic              v4_q;
	logic              resp_q;
	logic              rewrite_q;
	logic [ADDR_W-1:0] sh_q, sl_q, dh_q, dl_q;
	logic [AW-1:0]     idx_q;
	logic              full_q;

	lk_status_t        lk_status;
	logic [AW-1:0]     lk_index;
	logic              out_free;

	logic [ORD_W-1:0]  order_num;
	logic [ADDR_W-1:0] new_lo;
	logic [ADDR_W-1:0] nsh, nsl, ndh, ndl;

	logic              out_valid_q;
	logic              out_keep_q;
	logic [ADDR_W-1:0] out_sh_q, out_sl_q, out_dh_q, out_dl_q;
	logic              out_clr_q;
	logic              out_full_q;

	assign in_sport = s_axis_tdata[15:0];
	assign in_dport = s_axis_tdata[31:16];
	assign in_plen  = s_axis_tdata[47:32];
	assign in_sh    = s_axis_tdata[111:48];
	assign in_sl    = s_axis_tdata[175:112];
	assign in_dh    = s_axis_tdata[239:176];
	assign in_dl    = s_axis_tdata[303:240];
	assign in_ver   = s_axis_tuser[3:0];
	assign in_resp  = s_axis_tuser[4];

	assign in_keep = (in_dport == service_port_q) ||
	                 ((in_sport == service_port_q) && (in_plen > header_length_q));
	assign in_v4      = (in_ver == VER_IPV4);
	assign in_rewrite = in_keep && (in_v4 || (in_ver == VER_IPV6));
	assign sel_hi     = in_resp ? in_dh : in_sh;
	assign sel_lo     = in_resp ? in_dl : in_sl;
	// IPv4 keys use only the 32-bit address
	assign in_key = in_v4 ? {1'b0, {ADDR_W{1'b0}}, 32'd0, sel_lo[31:0]}
	                      : {1'b1, sel_hi, sel_lo};

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	dpaa_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_lookup (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && in_rewrite),
		.key   (in_key),
		.status(lk_status),
		.index (lk_index)
	);

	always_comb begin
		order_num = ORD_W'(idx_q);
		if (full_q) begin
			new_lo = '0;
		end else if (v4_q) begin
			new_lo = {32'd0, swap_bytes32(order_num)};
		end else begin
			new_lo = {32'd0, order_num};
		end
		nsh = sh_q;
		nsl = sl_q;
		ndh = dh_q;
		ndl = dl_q;
		if (rewrite_q) begin
			if (resp_q) begin
				ndh = '0;
				ndl = new_lo;
			end else begin
				nsh = '0;
				nsl = new_lo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			service_port_q  <= SERVICE_PORT_RESET;
			header_length_q <= HEADER_LENGTH_RESET;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SERVICE_PORT:  service_port_q  <= cfg_data;
					REG_HEADER_LENGTH: header_length_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= in_rewrite ? S_LOOKUP : S_FINISH;
					end
				end
				S_LOOKUP: begin
					if (lk_status.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			keep_q    <= in_keep;
			v4_q      <= in_v4;
			resp_q    <= in_resp;
			rewrite_q <= in_rewrite;
			sh_q      <= in_sh;
			sl_q      <= in_sl;
			dh_q      <= in_dh;
			dl_q      <= in_dl;
			idx_q     <= '0;
			full_q    <= 1'b0;
		end else if (state_q == S_LOOKUP && lk_status.done) begin
			idx_q  <= lk_index;
			full_q <= lk_status.full;
		end
		if (state_q == S_FINISH && out_free) begin
			out_keep_q <= keep_q;
			out_sh_q   <= nsh;
			out_sl_q   <= nsl;
			out_dh_q   <= ndh;
			out_dl_q   <= ndl;
			out_clr_q  <= rewrite_q && v4_q;
			out_full_q <= rewrite_q && full_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_full_q, out_clr_q, out_dl_q, out_dh_q,
	                        out_sl_q, out_sh_q, out_keep_q};

	a_done_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		lk_status.done |-> state_q == S_LOOKUP)
		else $error("lookup finished outside the lookup phase");

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second item accepted while one is in progress");

	a_full_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[258]) |-> m_axis_tdata[0])
		else $error("table full flagged on a dropped packet");

	a_clr_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[257]) |-> m_axis_tdata[0])
		else $error("checksum clear flagged on a dropped packet");

endmodule

[tb/sv/dns_packet_address_anonymizer_tb.sv]
`timescale 1ns / 1ps

module dns_packet_address_anonymizer_tb;
	import dpaa_pkg::*;

	localparam int TABLE_DEPTH     = 256;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int PHASES          = 4;
	localparam int HOLD_CYCLES     = 1500;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_CYCLES    = 300;
	localparam int CYCLE_LIMIT     = 2000000;
	localparam int FRESH_PCT       = 85;

	typedef struct {
		logic [3:0]        ver;
		logic [PORT_W-1:0] sport;
		logic [PORT_W-1:0] dport;
		logic [PORT_W-1:0] plen;
		logic              resp;
		logic [ADDR_W-1:0] sh;
		logic [ADDR_W-1:0] sl;
		logic [ADDR_W-1:0] dh;
		logic [ADDR_W-1:0] dl;
	} pkt_t;

	typedef struct {
		logic              keep;
		logic [ADDR_W-1:0] sh;
		logic [ADDR_W-1:0] sl;
		logic [ADDR_W-1:0] dh;
		logic [ADDR_W-1:0] dl;
		logic              clr;
		logic              full;
	} verdict_t;

	typedef struct {
		pkt_t     pkt;
		bit       typed;
		verdict_t want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// src_port, dst_port, payload_length, source_high, source_low,
	// destination_high, destination_low
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	// ip_version, response_flag
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// keep_packet, new_source_high, new_source_low, new_destination_high,
	// new_destination_low, clear_checksum, table_full, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [PORT_W-1:0]     cfg_data;

	// mirror of the block's configuration and address table
	logic [PORT_W-1:0] svc_port = SERVICE_PORT_RESET;
	logic [PORT_W-1:0] hdr_len  = HEADER_LENGTH_RESET;
	logic [ADDR_W-1:0] tbl_hi[TABLE_DEPTH];
	logic [ADDR_W-1:0] tbl_lo[TABLE_DEPTH];
	logic              tbl_v6[TABLE_DEPTH];
	int                used_entries = 0;

	verdict_t  pending_verdicts[$];
	verdict_t  no_verdict;
	stim_row_t directed_rows[$];

	// addresses offered so far, reused to hit existing table entries
	logic [31:0]       v4_seen[$];
	logic [ADDR_W-1:0] v6_seen_hi[$];
	logic [ADDR_W-1:0] v6_seen_lo[$];

	int idle_pct   = 0;
	int stall_pct  = 0;
	int hold_seq   = 0;
	int hold_seen  = 0;
	int hold_left  = 0;
	int mismatches = 0;
	int cycles     = 0;

	dns_packet_address_anonymizer #(.TABLE_DEPTH(TABLE_DEPTH)) uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[dns_packet_address_anonymizer] ERROR");
			$finish;
		end
	end

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic pkt_t mk_pkt(input logic [3:0] ver, input logic [PORT_W-1:0] sport,
			input logic [PORT_W-1:0] dport, input logic [PORT_W-1:0] plen, input logic resp,
			input logic [ADDR_W-1:0] sh, input logic [ADDR_W-1:0] sl,
			input logic [ADDR_W-1:0] dh, input logic [ADDR_W-1:0] dl);
		pkt_t p;
		p.ver = ver; p.sport = sport; p.dport = dport; p.plen = plen; p.resp = resp;
		p.sh = sh; p.sl = sl; p.dh = dh; p.dl = dl;
		return p;
	endfunction

	function automatic verdict_t mk_verdict(input logic keep, input logic [ADDR_W-1:0] sh,
			input logic [ADDR_W-1:0] sl, input logic [ADDR_W-1:0] dh,
			input logic [ADDR_W-1:0] dl, input logic clr, input logic full);
		verdict_t v;
		v.keep = keep; v.sh = sh; v.sl = sl; v.dh = dh; v.dl = dl;
		v.clr = clr; v.full = full;
		return v;
	endfunction

	// addresses unchanged, no checksum clear, no table overflow
	function automatic verdict_t passed(input pkt_t p, input logic keep);
		return mk_verdict(keep, p.sh, p.sl, p.dh, p.dl, 1'b0, 1'b0);
	endfunction

	// Filter the packet and replace one address by its first-seen order number.
	function automatic verdict_t anonymize(input pkt_t p);
		verdict_t          v;
		logic              v6;
		logic [ADDR_W-1:0] k_hi;
		logic [ADDR_W-1:0] k_lo;
		logic [ADDR_W-1:0] repl;
		logic [31:0]       n;
		logic              found;
		int                i;
		v = passed(p, (p.dport == svc_port) || (p.sport == svc_port && p.plen > hdr_len));
		if (v.keep && (p.ver == VER_IPV4 || p.ver == VER_IPV6)) begin
			v6 = (p.ver == VER_IPV6);
			k_hi = v6 ? (p.resp ? p.dh : p.sh) : '0;
			k_lo = p.resp ? p.dl : p.sl;
			if (!v6)
				k_lo = {32'd0, k_lo[31:0]};
			found = 1'b0;
			n = '0;
			for (i = 0; i < used_entries; i++) begin
				if (!found && tbl_v6[i] == v6 && tbl_hi[i] == k_hi && tbl_lo[i] == k_lo) begin
					found = 1'b1;
					n = 32'(i);
				end
			end
			if (!found) begin
				if (used_entries >= TABLE_DEPTH) begin
					v.full = 1'b1;
				end else begin
					tbl_v6[used_entries] = v6;
					tbl_hi[used_entries] = k_hi;
					tbl_lo[used_entries] = k_lo;
					n = 32'(used_entries);
					used_entries++;
				end
			end
			// IPv4 carries the number little-endian in wire order
			if (v.full)
				repl = '0;
			else if (v6)
				repl = {32'd0, n};
			else
				repl = {32'd0, n[7:0], n[15:8], n[23:16], n[31:24]};
			if (p.resp) begin
				v.dh = '0;
				v.dl = repl;
			end else begin
				v.sh = '0;
				v.sl = repl;
			end
			v.clr = !v6;
		end
		return v;
	endfunction

	function automatic void add_row(input pkt_t p, input bit typed, input verdict_t want);
		stim_row_t row;
		row.pkt = p;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	function automatic void load_directed();
		pkt_t p;
		// dropped
		p = mk_pkt(VER_IPV4, 16'd1000, 16'd80, 16'd100, 1'b0, 64'h0123_4567_89AB_CDEF,
			64'hFEDC_BA98_7654_3210, 64'h0, 64'h0A00_0001);
		add_row(p, 1'b1, passed(p, 1'b0));
		// IPv4 query, upper bits ignored, first entry
		p = mk_pkt(VER_IPV4, 16'd1234, 16'd53, 16'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hDEAD_BEEF_C0A8_0001, 64'h0, 64'h0A00_0001);
		add_row(p, 1'b1, mk_verdict(1'b1, 64'h0, 64'h0, 64'h0, 64'h0A00_0001, 1'b1, 1'b0));
		// IPv4 response kept by source port and a payload one past the header
		p = mk_pkt(VER_IPV4, 16'd53, 16'd5000, 16'd13, 1'b1, 64'h0, 64'hC0A8_0001,
			64'h0, 64'h0A00_0001);
		add_row(p, 1'b1, mk_verdict(1'b1, 64'h0, 64'hC0A8_0001, 64'h0, 64'h0100_0000,
			1'b1, 1'b0));
		// source port only, payload equal to the header: dropped
		p = mk_pkt(VER_IPV4, 16'd53, 16'd1, 16'd12, 1'b0, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h3333_3333_3333_3333, 64'hCCCC_CCCC_CCCC_CCCC);
		add_row(p, 1'b1, passed(p, 1'b0));
		// IPv6 query, all-ones address
		p = mk_pkt(VER_IPV6, 16'd999, 16'd53, 16'd40, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h2001_0DB8_0000_0001, 64'h5);
		add_row(p, 1'b1, mk_verdict(1'b1, 64'h0, 64'd2, 64'h2001_0DB8_0000_0001, 64'h5,
			1'b0, 1'b0));
		// IPv6 key equal to an IPv4 key: separate key space
		p = mk_pkt(VER_IPV6, 16'd999, 16'd53, 16'd40, 1'b0, 64'h0, 64'hC0A8_0001,
			64'h0, 64'h0);
		add_row(p, 1'b1, mk_verdict(1'b1, 64'h0, 64'd3, 64'h0, 64'h0, 1'b0, 1'b0));
		// known IPv4 address again
		p = mk_pkt(VER_IPV4, 16'd999, 16'd53, 16'd40, 1'b0, 64'h1234, 64'hC0A8_0001,
			64'h0, 64'h0);
		add_row(p, 1'b1, mk_verdict(1'b1, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b0));
		// other IP versions pass through
		p = mk_pkt(4'd0, 16'd999, 16'd53, 16'd40, 1'b0, 64'h1111_2222_3333_4444,
			64'h5555_6666_7777_8888, 64'h9999_AAAA_BBBB_CCCC, 64'hDDDD_EEEE_FFFF_0000);
		add_row(p, 1'b1, passed(p, 1'b1));
		p = mk_pkt(4'd15, 16'd999, 16'd53, 16'd40, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_row(p, 1'b1, passed(p, 1'b1));
		p = mk_pkt(4'd5, 16'd53, 16'd7, 16'hFFFF, 1'b0, 64'h0, 64'h1, 64'h2, 64'h3);
		add_row(p, 1'b1, passed(p, 1'b1));
		// all-zero IPv4 address is a key like any other
		p = mk_pkt(VER_IPV4, 16'd999, 16'd53, 16'd40, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0);
		add_row(p, 1'b1, mk_verdict(1'b1, 64'h0, 64'h0400_0000, 64'h0, 64'h0, 1'b1, 1'b0));
		p = mk_pkt(VER_IPV6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_row(p, 1'b1, passed(p, 1'b0));
		p = mk_pkt(VER_IPV4, 16'd53, 16'd53, 16'd0, 1'b1, 64'h0, 64'hC0A8_0001,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_row(p, 1'b1, mk_verdict(1'b1, 64'h0, 64'hC0A8_0001, 64'h0, 64'h0500_0000,
			1'b1, 1'b0));
		p = mk_pkt(VER_IPV6, 16'd53, 16'd0, 16'hFFFF, 1'b1, 64'h0, 64'h0,
			64'h2001_0DB8_0000_0000, 64'h1);
		add_row(p, 1'b1, mk_verdict(1'b1, 64'h0, 64'h0, 64'h0, 64'd6, 1'b0, 1'b0));
		// repeats and near misses, checked by the predictor
		add_row(mk_pkt(VER_IPV6, 16'd1, 16'd53, 16'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0), 1'b0, no_verdict);
		add_row(mk_pkt(VER_IPV4, 16'd1, 16'd53, 16'd0, 1'b1, 64'h0, 64'h0,
			64'h7, 64'hFFFF_FFFF_0A00_0001), 1'b0, no_verdict);
		add_row(mk_pkt(VER_IPV6, 16'd1, 16'd53, 16'd0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0),
			1'b0, no_verdict);
		p = mk_pkt(VER_IPV4, 16'd53, 16'd0, 16'd0, 1'b0, 64'h0, 64'h9, 64'h0, 64'h0);
		add_row(p, 1'b1, passed(p, 1'b0));
		add_row(mk_pkt(VER_IPV4, 16'd1, 16'd53, 16'd0, 1'b0, 64'h0, 64'h0000_0000_FFFF_FFFF,
			64'h0, 64'h0), 1'b0, no_verdict);
	endfunction

	function automatic pkt_t gen_item();
		pkt_t              p;
		int                pick;
		logic [31:0]       v4_addr;
		logic [ADDR_W-1:0] a_hi;
		logic [ADDR_W-1:0] a_lo;
		p.sh = rand64();
		p.sl = rand64();
		p.dh = rand64();
		p.dl = rand64();
		p.sport = 16'($urandom);
		p.dport = 16'($urandom);
		p.plen = 16'($urandom);
		p.resp = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 46)
			p.ver = VER_IPV4;
		else if (pick < 92)
			p.ver = VER_IPV6;
		else
			p.ver = 4'($urandom_range(15));
		pick = $urandom_range(99);
		if (pick < 40) begin
			p.dport = svc_port;
		end else if (pick < 75) begin
			// payload around the header length boundary
			p.sport = svc_port;
			case ($urandom_range(3))
				0: p.plen = hdr_len;
				1: p.plen = hdr_len + 16'd1;
				2: p.plen = hdr_len - 16'd1;
				default: ;
			endcase
		end
		// mostly fresh addresses, so the table runs full during the run
		if (p.ver == VER_IPV6) begin
			if (v6_seen_hi.size() == 0 || $urandom_range(99) < FRESH_PCT) begin
				a_hi = rand64();
				a_lo = rand64();
				v6_seen_hi.push_back(a_hi);
				v6_seen_lo.push_back(a_lo);
			end else begin
				pick = $urandom_range(v6_seen_hi.size() - 1);
				a_hi = v6_seen_hi[pick];
				a_lo = v6_seen_lo[pick];
			end
		end else begin
			if (v4_seen.size() == 0 || $urandom_range(99) < FRESH_PCT) begin
				v4_addr = $urandom;
				v4_seen.push_back(v4_addr);
			end else begin
				v4_addr = v4_seen[$urandom_range(v4_seen.size() - 1)];
			end
			a_hi = rand64();
			a_lo = {$urandom, v4_addr};
		end
		if (p.resp) begin
			p.dh = a_hi;
			p.dl = a_lo;
		end else begin
			p.sh = a_hi;
			p.sl = a_lo;
		end
		return p;
	endfunction

	task automatic send_item(input pkt_t p, input bit typed, input verdict_t want);
		verdict_t calc;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.dl, p.dh, p.sl, p.sh, p.plen, p.dport, p.sport};
		s_axis_tuser <= {p.resp, p.ver};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		calc = anonymize(p);
		pending_verdicts.push_back(typed ? want : calc);
	endtask

	// drop valid and hold until every predicted result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_verdicts.size() != 0);
	endtask

	task automatic set_config(input logic [PORT_W-1:0] port, input logic [PORT_W-1:0] hlen);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SERVICE_PORT;
		cfg_data <= port;
		@(posedge clk);
		cfg_index <= REG_HEADER_LENGTH;
		cfg_data <= hlen;
		@(posedge clk);
		cfg_we <= 1'b0;
		svc_port = port;
		hdr_len = hlen;
	endtask

	function automatic void cmp_field(input string name, input logic [ADDR_W-1:0] exp_val,
			input logic [ADDR_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %h, got %h", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	task automatic check_verdict(input logic [OUT_DATA_W-1:0] d);
		verdict_t w;
		if (pending_verdicts.size() == 0) begin
			$error("result item with no prediction waiting: %h", d);
			mismatches++;
		end else begin
			w = pending_verdicts.pop_front();
			cmp_field("keep_packet", 64'(w.keep), 64'(d[0]));
			cmp_field("new_source_high", w.sh, d[64:1]);
			cmp_field("new_source_low", w.sl, d[128:65]);
			cmp_field("new_destination_high", w.dh, d[192:129]);
			cmp_field("new_destination_low", w.dl, d[256:193]);
			cmp_field("clear_checksum", 64'(w.clr), 64'(d[257]));
			cmp_field("table_full", 64'(w.full), 64'(d[258]));
		end
	endtask

	// result side: check accepted items, then pick tready for the next edge
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			check_verdict(m_axis_tdata);
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int phase;
		int k;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SERVICE_PORT;
		cfg_data = '0;
		arst_n = 1'b0;
		load_directed();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[r])
			send_item(directed_rows[r].pkt, directed_rows[r].typed, directed_rows[r].want);
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					set_config(SERVICE_PORT_RESET, HEADER_LENGTH_RESET);
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					set_config(16'd0, 16'd0);
					idle_pct = 45;
					stall_pct = 0;
				end
				2: begin
					set_config(16'hFFFF, 16'hFFFF);
					idle_pct = 0;
					stall_pct = 45;
				end
				default: begin
					set_config(16'($urandom), 16'($urandom_range(2000)));
					idle_pct = 8;
					stall_pct = 8;
				end
			endcase
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// long output hold-off while items keep coming
				if (phase == 0 && k == 40)
					hold_seq <= hold_seq + 1;
				if (phase == 1 && k == 100)
					wait_drained();
				send_item(gen_item(), 1'b0, no_verdict);
			end
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[dns_packet_address_anonymizer] OK");
		else
			$display("[dns_packet_address_anonymizer] ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/core/dpaa_pkg.sv
rtl/core/dpaa_ram.sv
rtl/core/dpaa_lookup.sv
rtl/core/dns_packet_address_anonymizer.sv
tb/sv/dns_packet_address_anonymizer_tb.sv
